// ===== design/schlick_fresnel_reflectance_defines.svh =====
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance - assertion macros
// Shared concurrent check forms, clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCHLICK_FRESNEL_REFLECTANCE_DEFINES_SVH
`define SCHLICK_FRESNEL_REFLECTANCE_DEFINES_SVH

// same-cycle implication
`define SFR_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFR_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance - package
// Fixed-point constants and pipeline unit sizes.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int unsigned COMP_W   = 16;   // Q1.14 vector component
    localparam int unsigned IDX_W    = 15;   // Q3.12 refractive index
    localparam int unsigned REFL_W   = 16;   // Q1.15 reflectance
    localparam int unsigned FRAC_W   = 28;
    localparam int unsigned CW       = 29;   // Q.28 values in [0, 1.0]

    localparam logic [CW-1:0] ONE_Q28  = 29'h1000_0000;
    localparam logic [30:0]   ONE_Q30  = 31'h4000_0000;
    localparam logic [REFL_W-1:0] REFL_ONE = 16'h8000;

    // sin^2 of transmitted angle: n1^2 (1 - cos^2) / n2^2
    localparam int unsigned SIN_NW = 59;
    localparam int unsigned SIN_DW = 30;
    localparam int unsigned SIN_QW = 29;

    // r0: d^2 2^30 / s^2
    localparam int unsigned R0_NW = 60;
    localparam int unsigned R0_DW = 32;
    localparam int unsigned R0_QW = 31;

    // transmitted cosine root
    localparam int unsigned SQRT_RW = 29;

    // multiplies in (1 - cos)^5
    localparam int unsigned POW_STEPS = 4;

endpackage

// ===== design/sfr_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance - pipelined restoring divider
// One quotient bit per stage; needs i_num < i_den * 2^QW.
// ----------------------------------------------------------------------------
module sfr_div_pipe #(
    parameter int unsigned NW = sfr_pkg::SIN_NW,
    parameter int unsigned DW = sfr_pkg::SIN_DW,
    parameter int unsigned QW = sfr_pkg::SIN_QW
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int unsigned WW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    genvar g;
    for (g = 0; g < QW; g++) begin : g_stage
        localparam int unsigned SH = QW - 1 - g;

        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [WW-1:0] trial;
        logic          take;

        if (g == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
        end

        assign trial = WW'(den_in) << SH;
        assign take  = WW'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= take ? NW'(WW'(rem_in) - trial) : rem_in;
                r_den[g] <= den_in;
                r_quo[g] <= take ? (quo_in | (QW'(1) << SH)) : quo_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== design/sfr_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance - pipelined integer square root
// One root bit per stage, floor(sqrt(i_rad)).
// ----------------------------------------------------------------------------
module sfr_sqrt_pipe #(
    parameter int unsigned RW = sfr_pkg::SQRT_RW
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_rad,
    output logic [RW-1:0]   o_root
);

    localparam int unsigned TW = 2 * RW + 1;

    logic [2*RW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];

    genvar g;
    for (g = 0; g < RW; g++) begin : g_stage
        localparam int unsigned SH = RW - 1 - g;

        logic [2*RW-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [TW-1:0]   trial;
        logic            take;

        if (g == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        // (root + 2^SH)^2 - root^2
        assign trial = (TW'(root_in) << (SH + 1)) + (TW'(1) << (2 * SH));
        assign take  = TW'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= take ? (2*RW)'(TW'(rem_in) - trial) : rem_in;
                r_root[g] <= take ? (root_in | (RW'(1) << SH)) : root_in;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== design/schlick_fresnel_reflectance.sv =====
// Throughput: one request per cycle while o_stall is low, fixed by the fully pipelined divider
// and square-root stages (one quotient or root bit per stage).
// A result stalled at the output moves into a one-entry skid register; the
// pipeline halts only while that register is full.
// Reset (i_rst_n, synchronous, active low) clears valid bits and the skid.
// ----------------------------------------------------------------------------
// Schlick Fresnel reflectance
// cos = clamp(camera . normal), total internal reflection check, transmitted
// cosine, then r0 + (1 - r0)(1 - cos)^5 rounded to Q1.15.
// ----------------------------------------------------------------------------
`include "schlick_fresnel_reflectance_defines.svh"

module schlick_fresnel_reflectance (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [sfr_pkg::COMP_W-1:0]  i_camera_x,
    input  logic signed [sfr_pkg::COMP_W-1:0]  i_camera_y,
    input  logic signed [sfr_pkg::COMP_W-1:0]  i_camera_z,
    input  logic signed [sfr_pkg::COMP_W-1:0]  i_normal_x,
    input  logic signed [sfr_pkg::COMP_W-1:0]  i_normal_y,
    input  logic signed [sfr_pkg::COMP_W-1:0]  i_normal_z,
    input  logic        [sfr_pkg::IDX_W-1:0]   i_index_from,
    input  logic        [sfr_pkg::IDX_W-1:0]   i_index_to,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic        [sfr_pkg::REFL_W-1:0]  o_reflectance,
    output logic                               o_total_internal
);

    // stage map: 1 products, 2 clamp, 3 cos^2, 4 numerator, 5 TIR test,
    // 6..34 sin^2 divide, 35 radicand, 36..64 root, 65 1-cos,
    // 66..69 powers, 70 blend multiply, 71 round.  r0 divide runs
    // from stage 2 to 32 and is delayed to line up with stage 69.
    localparam int unsigned NST    = 5 + sfr_pkg::SIN_QW + 1 + sfr_pkg::SQRT_RW + 1
                                   + sfr_pkg::POW_STEPS + 2;
    localparam int unsigned R0_DLY = (NST - 2) - (1 + sfr_pkg::R0_QW);
    localparam int unsigned PS     = sfr_pkg::POW_STEPS;
    localparam int unsigned CW     = sfr_pkg::CW;

    typedef struct packed {
        logic [CW-1:0] c;
        logic          gt;
        logic          tir;
    } t_side;

    logic en;
    logic [NST-1:0] r_v;

    // skid
    logic                       r_skid_v;
    logic [sfr_pkg::REFL_W-1:0] r_skid_refl;
    logic                       r_skid_tir;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    // ---------------- stage 1: products ----------------
    logic signed [31:0] r_s1_pxx, r_s1_pyy, r_s1_pzz;
    logic [29:0]        r_s1_n1sq, r_s1_n2sq, r_s1_d2;
    logic [31:0]        r_s1_s2;
    logic               r_s1_gt;
    logic [14:0]        s_diff;
    logic [15:0]        s_sum;
    logic               s_gt;

    assign s_gt   = i_index_from > i_index_to;
    assign s_diff = s_gt ? (i_index_from - i_index_to) : (i_index_to - i_index_from);
    assign s_sum  = 16'(i_index_from) + 16'(i_index_to);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pxx  <= i_camera_x * i_normal_x;
            r_s1_pyy  <= i_camera_y * i_normal_y;
            r_s1_pzz  <= i_camera_z * i_normal_z;
            r_s1_n1sq <= i_index_from * i_index_from;
            r_s1_n2sq <= i_index_to * i_index_to;
            r_s1_d2   <= s_diff * s_diff;
            r_s1_s2   <= s_sum * s_sum;
            r_s1_gt   <= s_gt;
        end
    end

    // r0 divider; a zero sum means a zero numerator, so divide 0 by 1
    logic [sfr_pkg::R0_QW-1:0] w_r0;

    sfr_div_pipe #(
        .NW (sfr_pkg::R0_NW),
        .DW (sfr_pkg::R0_DW),
        .QW (sfr_pkg::R0_QW)
    ) u_div_r0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_s1_d2, 30'b0}),
        .i_den ((r_s1_s2 == '0) ? 32'd1 : r_s1_s2),
        .o_quo (w_r0)
    );

    // ---------------- stage 2: clamp cos ----------------
    logic signed [32:0] s_dot;
    logic [CW-1:0]      r_s2_c;
    logic [29:0]        r_s2_n1sq, r_s2_n2sq;
    logic               r_s2_gt;

    assign s_dot = 33'(r_s1_pxx) + 33'(r_s1_pyy) + 33'(r_s1_pzz);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (s_dot[32]) begin
                r_s2_c <= '0;
            end else if (s_dot > 33'sd268435456) begin
                r_s2_c <= sfr_pkg::ONE_Q28;
            end else begin
                r_s2_c <= s_dot[CW-1:0];
            end
            r_s2_n1sq <= r_s1_n1sq;
            r_s2_n2sq <= r_s1_n2sq;
            r_s2_gt   <= r_s1_gt;
        end
    end

    // ---------------- stage 3: cos^2 ----------------
    logic [57:0]   s_csq;
    logic [CW-1:0] r_s3_c2, r_s3_c;
    logic [29:0]   r_s3_n1sq, r_s3_n2sq;
    logic          r_s3_gt;

    assign s_csq = r_s2_c * r_s2_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_c2   <= s_csq[56:28];
            r_s3_c    <= r_s2_c;
            r_s3_n1sq <= r_s2_n1sq;
            r_s3_n2sq <= r_s2_n2sq;
            r_s3_gt   <= r_s2_gt;
        end
    end

    // ---------------- stage 4: n1^2 (1 - cos^2) ----------------
    logic [CW-1:0]               s_omc2;
    logic [sfr_pkg::SIN_NW-1:0]  r_s4_num;
    logic [CW-1:0]               r_s4_c;
    logic [29:0]                 r_s4_n2sq;
    logic                        r_s4_gt;

    assign s_omc2 = sfr_pkg::ONE_Q28 - r_s3_c2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_num  <= r_s3_n1sq * s_omc2;
            r_s4_c    <= r_s3_c;
            r_s4_n2sq <= r_s3_n2sq;
            r_s4_gt   <= r_s3_gt;
        end
    end

    // ---------------- stage 5: total internal reflection ----------------
    // zero n2 without TIR leaves a zero numerator: divide 0 by 1
    logic [sfr_pkg::SIN_NW-1:0] r_s5_num;
    logic [sfr_pkg::SIN_DW-1:0] r_s5_den;
    t_side                      r_s5_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_num      <= r_s4_num;
            r_s5_den      <= (r_s4_n2sq == '0) ? 30'd1 : r_s4_n2sq;
            r_s5_side.c   <= r_s4_c;
            r_s5_side.gt  <= r_s4_gt;
            r_s5_side.tir <= r_s4_gt && (r_s4_num > {1'b0, r_s4_n2sq, 28'b0});
        end
    end

    // ---------------- stages 6..34: sin^2 divide ----------------
    logic [sfr_pkg::SIN_QW-1:0] w_sin_q;
    t_side                      r_sd1 [sfr_pkg::SIN_QW];

    sfr_div_pipe #(
        .NW (sfr_pkg::SIN_NW),
        .DW (sfr_pkg::SIN_DW),
        .QW (sfr_pkg::SIN_QW)
    ) u_div_sin (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s5_num),
        .i_den (r_s5_den),
        .o_quo (w_sin_q)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd1[0] <= r_s5_side;
            for (int k = 1; k < int'(sfr_pkg::SIN_QW); k++) begin
                r_sd1[k] <= r_sd1[k-1];
            end
        end
    end

    // ---------------- stage 35: radicand (1 - sin^2) 2^28 ----------------
    logic [CW-1:0]                s_sin2;
    logic [2*sfr_pkg::SQRT_RW-1:0] r_s35_rad;
    t_side                        r_s35_side;

    assign s_sin2 = (w_sin_q > sfr_pkg::ONE_Q28) ? sfr_pkg::ONE_Q28 : w_sin_q;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s35_rad  <= {1'b0, sfr_pkg::ONE_Q28 - s_sin2, 28'b0};
            r_s35_side <= r_sd1[sfr_pkg::SIN_QW-1];
        end
    end

    // ---------------- stages 36..64: transmitted cosine ----------------
    logic [sfr_pkg::SQRT_RW-1:0] w_root;
    t_side                       r_sd2 [sfr_pkg::SQRT_RW];

    sfr_sqrt_pipe #(
        .RW (sfr_pkg::SQRT_RW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_s35_rad),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd2[0] <= r_s35_side;
            for (int k = 1; k < int'(sfr_pkg::SQRT_RW); k++) begin
                r_sd2[k] <= r_sd2[k-1];
            end
        end
    end

    // ---------------- stage 65: x = 1 - cos ----------------
    t_side         s_side65;
    logic [CW-1:0] s_root, s_cos;
    logic [CW-1:0] r_s65_x;
    logic          r_s65_tir;

    assign s_side65 = r_sd2[sfr_pkg::SQRT_RW-1];
    assign s_root   = (w_root > sfr_pkg::ONE_Q28) ? sfr_pkg::ONE_Q28 : w_root;
    assign s_cos    = s_side65.gt ? s_root : s_side65.c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s65_x   <= sfr_pkg::ONE_Q28 - s_cos;
            r_s65_tir <= s_side65.tir;
        end
    end

    // ---------------- stages 66..69: x^5, truncated each step ----------------
    logic [57:0]   s_pw_prod [PS];
    logic [CW-1:0] r_pw_x    [PS];
    logic [CW-1:0] r_pw_p    [PS];
    logic          r_pw_tir  [PS];

    always_comb begin
        s_pw_prod[0] = r_s65_x * r_s65_x;
        for (int k = 1; k < int'(PS); k++) begin
            s_pw_prod[k] = r_pw_p[k-1] * r_pw_x[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pw_x[0]   <= r_s65_x;
            r_pw_p[0]   <= s_pw_prod[0][56:28];
            r_pw_tir[0] <= r_s65_tir;
            for (int k = 1; k < int'(PS); k++) begin
                r_pw_x[k]   <= r_pw_x[k-1];
                r_pw_p[k]   <= s_pw_prod[k][56:28];
                r_pw_tir[k] <= r_pw_tir[k-1];
            end
        end
    end

    // r0 delay line, lines up with the last power stage
    logic [sfr_pkg::R0_QW-1:0] r_r0_dly [R0_DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r0_dly[0] <= w_r0;
            for (int k = 1; k < int'(R0_DLY); k++) begin
                r_r0_dly[k] <= r_r0_dly[k-1];
            end
        end
    end

    // ---------------- stage 70: (1 - r0) x^5 ----------------
    logic [30:0] s_omr0;
    logic [59:0] s_blend;
    logic [30:0] r_s70_m, r_s70_r0;
    logic        r_s70_tir;

    assign s_omr0  = sfr_pkg::ONE_Q30 - r_r0_dly[R0_DLY-1];
    assign s_blend = s_omr0 * r_pw_p[PS-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s70_m   <= s_blend[58:28];
            r_s70_r0  <= r_r0_dly[R0_DLY-1];
            r_s70_tir <= r_pw_tir[PS-1];
        end
    end

    // ---------------- stage 71: round to Q1.15 ----------------
    logic [31:0]                s_r;
    logic [16:0]                s_rr;
    logic [sfr_pkg::REFL_W-1:0] r_s71_refl;
    logic                       r_s71_tir;

    assign s_r  = 32'(r_s70_r0) + 32'(r_s70_m) + 32'h0000_4000;
    assign s_rr = s_r[31:15];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s70_tir || (s_rr > 17'(sfr_pkg::REFL_ONE))) begin
                r_s71_refl <= sfr_pkg::REFL_ONE;
            end else begin
                r_s71_refl <= s_rr[sfr_pkg::REFL_W-1:0];
            end
            r_s71_tir <= r_s70_tir;
        end
    end

    // ---------------- output and skid ----------------
    // a stalled result leaves the pipeline for the skid; the skid always
    // holds the older result, so it is shown first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            r_skid_v <= i_stall;
        end else begin
            r_skid_v <= r_v[NST-1] && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_skid_refl <= r_s71_refl;
            r_skid_tir  <= r_s71_tir;
        end
    end

    assign o_valid          = r_skid_v || r_v[NST-1];
    assign o_reflectance    = r_skid_v ? r_skid_refl : r_s71_refl;
    assign o_total_internal = r_skid_v ? r_skid_tir : r_s71_tir;

    // ---------------- checks ----------------
    `SFR_CHECK(a_tir_full, o_valid && o_total_internal, o_reflectance == sfr_pkg::REFL_ONE, "TIR result not 1.0")
    `SFR_CHECK(a_refl_range, o_valid, o_reflectance <= sfr_pkg::REFL_ONE, "reflectance above 1.0")
    `SFR_CHECK_NEXT(a_skid_keep, r_skid_v && i_stall && i_rst_n, r_skid_v, "skid dropped a stalled result")
    `SFR_CHECK_NEXT(a_pipe_hold, r_skid_v && i_rst_n, r_v == $past(r_v), "pipeline moved while skid full")

endmodule
